// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FWLS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FWLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fwls_pkg.sv =====
package fwls_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RESET  = 2'd1,
    CMD_ENABLE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACCEL_THRESHOLD = 3'd0,
    REG_DETECT_TIME     = 3'd1,
    REG_STICK_DEADBAND  = 3'd2,
    REG_LAUNCH_TIMEOUT  = 3'd3,
    REG_MOTOR_DELAY     = 3'd4,
    REG_RUN_THROTTLE    = 3'd5,
    REG_IDLE_THROTTLE   = 3'd6,
    REG_CLIMB_PITCH     = 3'd7
  } reg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 26;  // 65535 ms in us fits in 26 bits
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] US_PER_MS     = 26'd1000;
  // smallest Q1.15 value not below cos(45 deg)
  localparam logic signed [15:0] LEVEL_COS_Q15 = 16'sd23171;

  typedef struct packed {
    logic [14:0]        accel_threshold;
    logic [LIMIT_W-1:0] detect_limit_us;
    logic [8:0]         stick_deadband;
    logic [LIMIT_W-1:0] timeout_us;
    logic [LIMIT_W-1:0] motor_delay_us;
    logic [10:0]        run_throttle;
    logic [10:0]        idle_throttle;
    logic signed [9:0]  climb_pitch_command;
  } cfg_t;

  typedef struct packed {
    cmd_t              command;
    logic [31:0]       time_us;
    logic signed [15:0] forward_accel;
    logic signed [15:0] tilt_cos;
    logic signed [9:0] roll_stick;
    logic signed [9:0] pitch_stick;
    logic [10:0]       throttle_stick;
  } item_t;

  typedef struct packed {
    logic              launch_finished;
    logic              launch_detected;
    logic              beeper_on;
    logic              reset_integrators;
    logic              motor_idle;
    logic signed [9:0] pitch_out;
    logic [10:0]       throttle_out;
  } res_t;

endpackage

// ===== sv/fwls_cfg.sv =====
module fwls_cfg import fwls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [LIMIT_W-1:0] data_us;

  // ms limits are kept in us
  assign data_us = LIMIT_W'(wr_data) * US_PER_MS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_ACCEL_THRESHOLD: cfg.accel_threshold <= wr_data[14:0];
        REG_DETECT_TIME:     cfg.detect_limit_us <= data_us;
        REG_STICK_DEADBAND:  cfg.stick_deadband <= wr_data[8:0];
        REG_LAUNCH_TIMEOUT:  cfg.timeout_us <= data_us;
        REG_MOTOR_DELAY:     cfg.motor_delay_us <= data_us;
        REG_RUN_THROTTLE:    cfg.run_throttle <= wr_data[10:0];
        REG_IDLE_THROTTLE:   cfg.idle_throttle <= wr_data[10:0];
        REG_CLIMB_PITCH:     cfg.climb_pitch_command <= wr_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/fwls_core.sv =====
module fwls_core import fwls_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [31:0] last_time, last_time_next;
  logic [31:0] accum, accum_next;
  logic [31:0] start_time, start_time_next;
  logic        detected, detected_next;
  logic        finished, finished_next;
  logic        allowed, allowed_next;

  logic [31:0] elapsed;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic [9:0]  roll_mag, pitch_mag;
  logic        accel_hi, level, stick_out;

  assign elapsed   = item.time_us - start_time;
  assign acc_sum   = {1'b0, accum} + {1'b0, item.time_us - last_time};
  assign acc_sat   = acc_sum[32] ? '1 : acc_sum[31:0];
  assign accel_hi  = item.forward_accel > $signed({1'b0, cfg.accel_threshold});
  assign level     = item.tilt_cos >= LEVEL_COS_Q15;
  assign roll_mag  = item.roll_stick[9] ? (~item.roll_stick + 10'd1) : item.roll_stick;
  assign pitch_mag = item.pitch_stick[9] ? (~item.pitch_stick + 10'd1) : item.pitch_stick;
  assign stick_out = (roll_mag > {1'b0, cfg.stick_deadband}) ||
                     (pitch_mag > {1'b0, cfg.stick_deadband});

  always_comb begin
    last_time_next  = last_time;
    accum_next      = accum;
    start_time_next = start_time;
    detected_next   = detected;
    finished_next   = finished;
    allowed_next    = allowed;

    res.throttle_out      = item.throttle_stick;
    res.pitch_out         = item.pitch_stick;
    res.motor_idle        = 1'b0;
    res.reset_integrators = 1'b0;
    res.beeper_on         = 1'b0;

    case (item.command)
      CMD_RESET: begin
        last_time_next  = item.time_us;
        accum_next      = '0;
        start_time_next = '0;
        detected_next   = 1'b0;
        finished_next   = 1'b0;
        allowed_next    = 1'b0;
      end
      CMD_ENABLE: begin
        start_time_next = item.time_us;
        allowed_next    = 1'b1;
      end
      CMD_TICK: begin
        if (detected) begin
          if (stick_out) finished_next = 1'b1;
          if (allowed) begin
            if (elapsed >= {6'b0, cfg.timeout_us}) finished_next = 1'b1;
            if (elapsed >= {6'b0, cfg.motor_delay_us}) begin
              res.throttle_out = cfg.run_throttle;
            end else begin
              res.throttle_out      = cfg.idle_throttle;
              res.motor_idle        = 1'b1;
              res.reset_integrators = 1'b1;
            end
          end
        end else begin
          if (accel_hi && level) begin
            accum_next = acc_sat;
            if (acc_sat >= {6'b0, cfg.detect_limit_us}) detected_next = 1'b1;
          end else begin
            accum_next = '0;
          end
          last_time_next        = item.time_us;
          res.throttle_out      = cfg.idle_throttle;
          res.motor_idle        = 1'b1;
          res.reset_integrators = 1'b1;
        end
        res.beeper_on = !finished_next;
        res.pitch_out = cfg.climb_pitch_command;
      end
      default: ;
    endcase

    res.launch_detected = detected_next;
    res.launch_finished = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      accum      <= '0;
      start_time <= '0;
      detected   <= 1'b0;
      finished   <= 1'b0;
      allowed    <= 1'b0;
    end else if (go) begin
      last_time  <= last_time_next;
      accum      <= accum_next;
      start_time <= start_time_next;
      detected   <= detected_next;
      finished   <= finished_next;
      allowed    <= allowed_next;
    end
  end

endmodule

// ===== sv/fixed_wing_launch_sequencer.sv =====
// Channel  Direction  Request moves
// s_*      in         command (tuser), time, accel, tilt, sticks, throttle (tdata)
// m_*      out        throttle, pitch, idle, integrator reset, beeper, flags (tdata)
// cfg_*    in         register index and write data
//
// One request per cycle sustained while m_tready holds; a stalled result holds back acceptance.
// Path: input register, then one pass through the sequencer logic into the result register.
// Reset (rst, synchronous) clears the sequencer state, configuration and both valid flags.
// A stalled result holds; the input register still takes a request when the result drains.
module fixed_wing_launch_sequencer import fwls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] time_us, [47:32] forward_accel, [63:48] tilt_cos, [73:64] roll_stick,
  // [83:74] pitch_stick, [94:84] throttle_stick, [95] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] command
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [10:0] throttle_out, [20:11] pitch_out, [21] motor_idle, [22] reset_integrators,
  // [23] beeper_on, [24] launch_detected, [25] launch_finished, [31:26] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  res_t  res, out_res;
  logic  in_vld;
  logic  advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld && (!m_tvalid || m_tready);
  assign s_tready  = !in_vld || advance;
  assign m_tdata   = {6'b0, out_res};

  fwls_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fwls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command        <= cmd_t'(s_tuser);
      in_item.time_us        <= s_tdata[31:0];
      in_item.forward_accel  <= s_tdata[47:32];
      in_item.tilt_cos       <= s_tdata[63:48];
      in_item.roll_stick     <= s_tdata[73:64];
      in_item.pitch_stick    <= s_tdata[83:74];
      in_item.throttle_stick <= s_tdata[94:84];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

endmodule

// ===== sv/fwls_checker.sv =====
`include "assert_macros.svh"

module fwls_checker import fwls_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  `FWLS_ASSERT_ALWAYS(a_no_result_after_reset, clk, rst |=> !m_tvalid, "result right after reset")
  `FWLS_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `FWLS_ASSERT(a_idle_with_int_reset, clk, rst, m_tvalid |-> m_tdata[21] == m_tdata[22], "motor idle and integrator reset differ")
  `FWLS_ASSERT(a_beep_not_finished, clk, rst, m_tvalid |-> !(m_tdata[23] && m_tdata[25]), "beeper on after launch finished")
  `FWLS_ASSERT(a_finished_needs_detect, clk, rst, m_tvalid && m_tdata[25] |-> m_tdata[24], "finished without detection")

endmodule

bind fixed_wing_launch_sequencer fwls_checker u_fwls_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/fwls_result_watch.sv =====
module fwls_result_watch import fwls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    awaiting
);

  // register shadow
  logic [14:0]       accel_thr;
  logic [15:0]       detect_ms;
  logic [8:0]        deadband;
  logic [15:0]       timeout_ms;
  logic [15:0]       delay_ms;
  logic [10:0]       launch_thr;
  logic [10:0]       idle_thr;
  logic signed [9:0] climb_pitch;

  // sequencer state
  logic [31:0] last_upd;
  logic [31:0] accum_us;
  logic [31:0] start_us;
  logic        detected;
  logic        finished;
  logic        motor_ok;

  res_t awaited[$];

  function automatic int stick_mag(logic signed [9:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic logic past_limit(logic [31:0] elapsed, logic [15:0] limit_ms);
    return {32'd0, elapsed} >= 64'(limit_ms) * 64'd1000;
  endfunction

  function automatic res_t step_sequencer(logic [1:0] cmd, logic [31:0] now,
                                          logic signed [15:0] accel,
                                          logic signed [15:0] tcos,
                                          logic signed [9:0] roll,
                                          logic signed [9:0] pitch,
                                          logic [10:0] thr_in);
    res_t r;
    logic [31:0] el;
    logic [32:0] sum;
    r = '0;
    r.throttle_out = thr_in;
    r.pitch_out = pitch;
    case (cmd)
      CMD_RESET: begin
        last_upd = now;
        accum_us = '0;
        start_us = '0;
        detected = 1'b0;
        finished = 1'b0;
        motor_ok = 1'b0;
      end
      CMD_ENABLE: begin
        start_us = now;
        motor_ok = 1'b1;
      end
      CMD_TICK: begin
        if (detected) begin
          el = now - start_us;
          if (stick_mag(roll) > int'(deadband) || stick_mag(pitch) > int'(deadband))
            finished = 1'b1;
          if (motor_ok) begin
            if (past_limit(el, timeout_ms))
              finished = 1'b1;
            if (past_limit(el, delay_ms)) begin
              r.throttle_out = launch_thr;
            end else begin
              r.reset_integrators = 1'b1;
              r.motor_idle = 1'b1;
              r.throttle_out = idle_thr;
            end
          end
        end else begin
          if (int'(accel) > int'(accel_thr) && tcos >= LEVEL_COS_Q15) begin
            sum = {1'b0, accum_us} + {1'b0, now - last_upd};
            accum_us = sum[32] ? '1 : sum[31:0];
            if (past_limit(accum_us, detect_ms))
              detected = 1'b1;
          end else begin
            accum_us = '0;
          end
          last_upd = now;
          r.reset_integrators = 1'b1;
          r.motor_idle = 1'b1;
          r.throttle_out = idle_thr;
        end
        r.beeper_on = !finished;
        r.pitch_out = climb_pitch;
      end
      default: ;
    endcase
    r.launch_detected = detected;
    r.launch_finished = finished;
    return r;
  endfunction

  task automatic compare(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    res_t a;
    if (rst) begin
      accel_thr = '0;
      detect_ms = '0;
      deadband = '0;
      timeout_ms = '0;
      delay_ms = '0;
      launch_thr = '0;
      idle_thr = '0;
      climb_pitch = '0;
      last_upd = '0;
      accum_us = '0;
      start_us = '0;
      detected = 1'b0;
      finished = 1'b0;
      motor_ok = 1'b0;
      awaited.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_THRESHOLD: accel_thr = cfg_data[14:0];
          REG_DETECT_TIME:     detect_ms = cfg_data;
          REG_STICK_DEADBAND:  deadband = cfg_data[8:0];
          REG_LAUNCH_TIMEOUT:  timeout_ms = cfg_data;
          REG_MOTOR_DELAY:     delay_ms = cfg_data;
          REG_RUN_THROTTLE:    launch_thr = cfg_data[10:0];
          REG_IDLE_THROTTLE:   idle_thr = cfg_data[10:0];
          REG_CLIMB_PITCH:     climb_pitch = cfg_data[9:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        awaited.push_back(step_sequencer(s_tuser, s_tdata[31:0], s_tdata[47:32],
                                         s_tdata[63:48], s_tdata[73:64],
                                         s_tdata[83:74], s_tdata[94:84]));
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          e = awaited.pop_front();
          a = res_t'(m_tdata[25:0]);
          compare("throttle_out", e.throttle_out, a.throttle_out);
          compare("pitch_out", e.pitch_out, a.pitch_out);
          compare("motor_idle", e.motor_idle, a.motor_idle);
          compare("reset_integrators", e.reset_integrators, a.reset_integrators);
          compare("beeper_on", e.beeper_on, a.beeper_on);
          compare("launch_detected", e.launch_detected, a.launch_detected);
          compare("launch_finished", e.launch_finished, a.launch_finished);
          compare("pad", 0, m_tdata[31:26]);
        end
      end
    end
    awaiting = awaited.size();
  end

endmodule

// ===== bench/tb_fixed_wing_launch_sequencer.sv =====
module tb_fixed_wing_launch_sequencer;
  import fwls_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES = 8;
  localparam int LONG_HOLD = 200;
  localparam int STALL_LIMIT = 4000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int awaiting;
  int send_idle_pct;
  int stall_pct;
  logic long_hold_go;
  logic long_hold_done;
  int sent_items;
  int quiet_cycles;

  // stimulus-side copy of the thresholds that shape flights
  int cur_thr;
  int cur_db;

  fixed_wing_launch_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fwls_result_watch watch (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    m_tready = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic write_reg(reg_idx_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_config(int thr, int det, int db, int tout, int dly, int lthr,
                             int ithr, int climb);
    write_reg(REG_ACCEL_THRESHOLD, thr);
    write_reg(REG_DETECT_TIME, det);
    write_reg(REG_STICK_DEADBAND, db);
    write_reg(REG_LAUNCH_TIMEOUT, tout);
    write_reg(REG_MOTOR_DELAY, dly);
    write_reg(REG_RUN_THROTTLE, lthr);
    write_reg(REG_IDLE_THROTTLE, ithr);
    write_reg(REG_CLIMB_PITCH, climb);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    cur_db = db;
  endtask

  task automatic send(logic [1:0] cmd, logic [31:0] t, int accel, int tilt, int roll,
                      int pitch, int thr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {1'b0, 11'(thr), 10'(pitch), 10'(roll), 16'(tilt), 16'(accel), t};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // reset, then ticks that mostly satisfy the detector, one motor enable, sticks
  // mostly inside the deadband, and a little noise
  task automatic run_flight(int n);
    logic [31:0] t;
    int en_at, sel, accel, tilt, roll, pitch;
    sel = $urandom_range(3);
    t = (sel == 0) ? 32'hFFFF_0000 + $urandom_range(65535) :
        (sel == 1) ? 32'($urandom_range(10000)) : $urandom;
    send(CMD_RESET, t, rand_between(-32768, 32767), rand_between(-32768, 32767),
         rand_between(-500, 500), rand_between(-500, 500), $urandom_range(2047));
    en_at = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      t += ($urandom_range(99) < 3) ? $urandom : $urandom_range(4000);
      if ($urandom_range(99) < 3) begin
        send($urandom_range(3), $urandom, rand_between(-32768, 32767),
             rand_between(-32768, 32767), rand_between(-500, 500),
             rand_between(-500, 500), $urandom_range(2047));
      end else begin
        if (cur_thr >= 32767 || $urandom_range(99) >= 85) begin
          accel = rand_between(-32768, 32767);
          tilt = ($urandom_range(1) == 0) ? rand_between(-32768, 23170) :
                 rand_between(23100, 32767);
          if ($urandom_range(3) == 0)
            accel = cur_thr;
        end else begin
          accel = rand_between(cur_thr + 1, 32767);
          tilt = rand_between(23171, 32767);
        end
        if ($urandom_range(99) < 92) begin
          roll = rand_between(-cur_db, cur_db);
          pitch = rand_between(-cur_db, cur_db);
        end else begin
          roll = rand_between(-500, 500);
          pitch = rand_between(-500, 500);
        end
        send((i == en_at) ? CMD_ENABLE : CMD_TICK, t, accel, tilt, roll, pitch,
             $urandom_range(2047));
      end
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold_go = 1'b0;
    sent_items = 0;
    quiet_cycles = 0;
    cur_thr = 0;
    cur_db = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // detection, motor delay, stick abort
    load_config(1000, 2, 100, 10, 3, 1800, 200, 300);
    send(CMD_RESET, 1000, 0, 0, 0, 0, 0);
    send(CMD_TICK, 1500, 32767, 32767, 0, 0, 2047);
    send(CMD_TICK, 2000, 32767, 23170, 0, 0, 5);
    send(CMD_TICK, 2500, 1001, 23171, 0, 0, 5);
    send(CMD_TICK, 3000, 1000, 32767, 0, 0, 5);
    send(CMD_TICK, 3500, 1001, 23171, 0, 0, 5);
    send(CMD_TICK, 5500, 5000, 30000, 0, 0, 5);
    send(CMD_TICK, 6000, -32768, -32768, 0, 0, 2047);
    send(CMD_ENABLE, 7000, 0, 0, 500, -500, 1234);
    send(CMD_TICK, 8000, 0, 0, 0, 0, 7);
    send(CMD_TICK, 10000, 0, 0, 0, 0, 7);
    send(CMD_TICK, 11000, 0, 0, 100, -100, 7);
    send(CMD_TICK, 12000, 0, 0, -101, 0, 7);
    send(CMD_SPARE, 13000, 32767, 32767, 500, -500, 0);
    send(CMD_TICK, 13500, 0, 0, 0, 0, 7);
    // timestamps across the 32-bit wrap, timeout
    send(CMD_RESET, 32'hFFFF_FE00, 0, 0, 0, 0, 0);
    send(CMD_TICK, 32'h0000_0100, 20000, 32767, 0, 0, 0);
    send(CMD_TICK, 32'h0000_0600, 20000, 32767, 0, 0, 0);
    send(CMD_ENABLE, 32'hFFFF_F000, 0, 0, 0, 0, 0);
    send(CMD_TICK, 32'h0000_2000, 0, 0, 0, 0, 0);
    drain();

    // accumulator saturation at the longest detect time
    load_config(0, 65535, 500, 65535, 65535, 2047, 2047, -500);
    send(CMD_RESET, 0, 0, 0, 0, 0, 0);
    send(CMD_TICK, 60000000, 1, 23171, 0, 0, 0);
    send(CMD_TICK, 60000000 + 32'hFFFF_0000, 1, 23171, 0, 0, 0);
    send(CMD_ENABLE, 100, 0, 0, 0, 0, 0);
    send(CMD_TICK, 200, 0, 0, 500, -500, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 0)
        load_config(0, 0, 0, 0, 0, 0, 0, 0);
      else if (p == 1)
        load_config(32767, 65535, 500, 65535, 65535, 2047, 2047, 500);
      else
        load_config(($urandom_range(9) == 0) ? 32767 : $urandom_range(3000),
                    $urandom_range(20), $urandom_range(500), $urandom_range(60),
                    $urandom_range(30), $urandom_range(2047), $urandom_range(2047),
                    rand_between(-500, 500));
      if (p == 4)
        long_hold_go = 1'b1;
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target)
        run_flight($urandom_range(4, 40));
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && awaiting == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
